@@ rtl/core/ats_pkg.sv @@
`timescale 1ns / 1ps

package ats_pkg;

    // Table size and fixed-point format.
    localparam int ENTRIES   = 64;
    localparam int FRAC_BITS = 16;

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int PROB_W = 7 + FRAC_BITS;
    localparam int RND_W  = 16;
    localparam int SUM_W  = PROB_W + 1;
    localparam int PROD_W = RND_W + CNT_W;
    localparam int CMP_W  = PROB_W + RND_W;

    // Probability of one in the stored format.
    localparam logic [PROB_W-1:0] ONE_FX = PROB_W'(1) << FRAC_BITS;

    // Input action codes.
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_DRAW = 1'b1;

    // Result kind codes.
    localparam logic KIND_BUILD = 1'b0;
    localparam logic KIND_DRAW  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DRAW,
        ST_CLS_RD,
        ST_CLS_PUSH,
        ST_PAIR_POP,
        ST_PAIR_RDS,
        ST_PAIR_RDL,
        ST_PAIR_UPD,
        ST_FLUSH_RD,
        ST_FLUSH_WR,
        ST_DONE
    } seq_state_t;

    typedef struct packed {
        logic             result_kind;
        logic [IDX_W-1:0] chosen_index;
        logic [CNT_W-1:0] entry_count;
        logic             table_ready;
        logic             overflowed;
    } result_t;

endpackage

@@ rtl/core/ats_if.sv @@
`timescale 1ns / 1ps

interface ats_in_if;
    logic                       valid;
    logic                       ready;
    logic                       action;
    logic [ats_pkg::PROB_W-1:0] weight;
    logic                       last_entry;
    logic [ats_pkg::RND_W-1:0]  pick_random;
    logic [ats_pkg::RND_W-1:0]  accept_random;

    modport source (
        output valid, action, weight, last_entry, pick_random, accept_random,
        input  ready
    );
    modport sink (
        input  valid, action, weight, last_entry, pick_random, accept_random,
        output ready
    );
endinterface

interface ats_out_if;
    logic                      valid;
    logic                      ready;
    logic                      result_kind;
    logic [ats_pkg::IDX_W-1:0] chosen_index;
    logic [ats_pkg::CNT_W-1:0] entry_count;
    logic                      table_ready;
    logic                      overflowed;

    modport source (
        output valid, result_kind, chosen_index, entry_count, table_ready, overflowed,
        input  ready
    );
    modport sink (
        input  valid, result_kind, chosen_index, entry_count, table_ready, overflowed,
        output ready
    );
endinterface

@@ rtl/core/alias_table_sampler_unit.sv @@
`timescale 1ns / 1ps

// Alias table sampler (Walker alias method) with fixed-point probabilities.
// The cmd channel carries one item per transfer: a load writes one weight in
// unsigned Q7.16 into the next table slot, and a draw brings two Q0.16
// uniforms. The res channel returns one result per draw and one per build.
// A load with last_entry set starts the table build; the block takes no
// further transfer on cmd until the build result is placed in the output
// register. A draw's transfer reads the probability and alias memories; the
// sequencer then compares and forms the result once the output register
// can take it. The build classifies each entry onto the small or large
// stack, pairs entries until a stack runs dry, and sets the entries left
// on the stacks to exactly one. The memory reads are registered, and every
// build step waits for the data it has read.
// A column whose probability ends at exactly one is always kept, so aliases
// from earlier tables are never observed and need no clearing pass.
// Reset empties the table, clears the flags and drops any pending result.
// When the receiver stalls, the result waits in the output register and the
// block still accepts the next cmd transfer; a draw or build then holds
// until the register frees up.
module alias_table_sampler_unit (
    input  logic      clk,
    input  logic      rst_n,
    ats_in_if.sink    cmd,
    ats_out_if.source res
);

    logic             push;
    logic             slot_free;
    ats_pkg::result_t result;

    // Sequencer with the table memories.
    ats_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .slot_free (slot_free),
        .push      (push),
        .result    (result)
    );

    // Output register toward the receiver.
    ats_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .result    (result),
        .slot_free (slot_free),
        .res       (res)
    );

endmodule

@@ rtl/core/ats_ram.sv @@
`timescale 1ns / 1ps

module ats_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/ats_seq.sv @@
`timescale 1ns / 1ps

// Sequencer for loads, draws and the table build. It owns the probability,
// alias and the two stack memories and does every access to them.
module ats_seq (
    input  logic             clk,
    input  logic             rst_n,
    ats_in_if.sink           cmd,
    input  logic             slot_free,
    output logic             push,
    output ats_pkg::result_t result
);

    ats_pkg::seq_state_t state_reg, state_next;

    logic [ats_pkg::CNT_W-1:0] count_reg, count_next;
    logic                      ready_reg, ready_next;
    logic                      ovf_reg, ovf_next;
    logic [ats_pkg::CNT_W-1:0] small_top_reg, small_top_next;
    logic [ats_pkg::CNT_W-1:0] large_top_reg, large_top_next;
    logic [ats_pkg::CNT_W-1:0] idx_reg, idx_next;
    logic                      flush_large_reg, flush_large_next;

    // Payload registers.
    logic [ats_pkg::IDX_W-1:0]  col_reg, col_next;
    logic [ats_pkg::RND_W-1:0]  accept_reg, accept_next;
    logic [ats_pkg::IDX_W-1:0]  l_idx_reg, l_idx_next;
    logic [ats_pkg::PROB_W-1:0] ps_reg, ps_next;

    // Memory ports.
    logic                       prob_we, prob_re;
    logic [ats_pkg::IDX_W-1:0]  prob_waddr, prob_raddr;
    logic [ats_pkg::PROB_W-1:0] prob_wdata, prob_rdata;
    logic                       alias_we, alias_re;
    logic [ats_pkg::IDX_W-1:0]  alias_waddr, alias_raddr;
    logic [ats_pkg::IDX_W-1:0]  alias_wdata, alias_rdata;
    logic                       sstk_we, sstk_re;
    logic [ats_pkg::IDX_W-1:0]  sstk_waddr, sstk_raddr, sstk_wdata, sstk_rdata;
    logic                       lstk_we, lstk_re;
    logic [ats_pkg::IDX_W-1:0]  lstk_waddr, lstk_raddr, lstk_wdata, lstk_rdata;

    // Datapath helpers.
    logic [ats_pkg::CNT_W-1:0]  base_count;
    logic                       base_ovf;
    logic [ats_pkg::PROD_W-1:0] prod;
    logic [ats_pkg::CNT_W-1:0]  col_full;
    logic [ats_pkg::IDX_W-1:0]  col_sel;
    logic [ats_pkg::SUM_W-1:0]  sum;
    logic [ats_pkg::SUM_W-1:0]  residue;
    logic [ats_pkg::CMP_W-1:0]  cmp_lhs, cmp_rhs;

    ats_ram #(.WIDTH(ats_pkg::PROB_W), .DEPTH(ats_pkg::ENTRIES)) u_prob_ram (
        .clk   (clk),
        .we    (prob_we),
        .waddr (prob_waddr),
        .wdata (prob_wdata),
        .re    (prob_re),
        .raddr (prob_raddr),
        .rdata (prob_rdata)
    );

    ats_ram #(.WIDTH(ats_pkg::IDX_W), .DEPTH(ats_pkg::ENTRIES)) u_alias_ram (
        .clk   (clk),
        .we    (alias_we),
        .waddr (alias_waddr),
        .wdata (alias_wdata),
        .re    (alias_re),
        .raddr (alias_raddr),
        .rdata (alias_rdata)
    );

    ats_ram #(.WIDTH(ats_pkg::IDX_W), .DEPTH(ats_pkg::ENTRIES)) u_small_ram (
        .clk   (clk),
        .we    (sstk_we),
        .waddr (sstk_waddr),
        .wdata (sstk_wdata),
        .re    (sstk_re),
        .raddr (sstk_raddr),
        .rdata (sstk_rdata)
    );

    ats_ram #(.WIDTH(ats_pkg::IDX_W), .DEPTH(ats_pkg::ENTRIES)) u_large_ram (
        .clk   (clk),
        .we    (lstk_we),
        .waddr (lstk_waddr),
        .wdata (lstk_wdata),
        .re    (lstk_re),
        .raddr (lstk_raddr),
        .rdata (lstk_rdata)
    );

    // A load after a finished build starts a new table.
    assign base_count = ready_reg ? '0 : count_reg;
    assign base_ovf   = ready_reg ? 1'b0 : ovf_reg;

    // Column choice: floor(pick * count / 2^16).
    assign prod     = ats_pkg::PROD_W'(cmd.pick_random) * ats_pkg::PROD_W'(count_reg);
    assign col_full = ats_pkg::CNT_W'(prod >> ats_pkg::RND_W);
    assign col_sel  = (col_full > ats_pkg::CNT_W'(ats_pkg::ENTRIES - 1))
                      ? ats_pkg::IDX_W'(ats_pkg::ENTRIES - 1)
                      : col_full[ats_pkg::IDX_W-1:0];

    // Residue of the large entry, saturating at zero.
    assign sum     = ats_pkg::SUM_W'(prob_rdata) + ats_pkg::SUM_W'(ps_reg);
    assign residue = (sum > ats_pkg::SUM_W'(ats_pkg::ONE_FX))
                     ? sum - ats_pkg::SUM_W'(ats_pkg::ONE_FX) : '0;

    assign cmp_lhs = ats_pkg::CMP_W'(accept_reg) << ats_pkg::FRAC_BITS;
    assign cmp_rhs = ats_pkg::CMP_W'(prob_rdata) << ats_pkg::RND_W;

    assign cmd.ready = (state_reg == ats_pkg::ST_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        ready_next       = ready_reg;
        ovf_next         = ovf_reg;
        small_top_next   = small_top_reg;
        large_top_next   = large_top_reg;
        idx_next         = idx_reg;
        flush_large_next = flush_large_reg;
        col_next         = col_reg;
        accept_next      = accept_reg;
        l_idx_next       = l_idx_reg;
        ps_next          = ps_reg;

        prob_we     = 1'b0;
        prob_waddr  = '0;
        prob_wdata  = '0;
        prob_re     = 1'b0;
        prob_raddr  = '0;
        alias_we    = 1'b0;
        alias_waddr = '0;
        alias_wdata = '0;
        alias_re    = 1'b0;
        alias_raddr = '0;
        sstk_we     = 1'b0;
        sstk_waddr  = '0;
        sstk_wdata  = '0;
        sstk_re     = 1'b0;
        sstk_raddr  = '0;
        lstk_we     = 1'b0;
        lstk_waddr  = '0;
        lstk_wdata  = '0;
        lstk_re     = 1'b0;
        lstk_raddr  = '0;

        push   = 1'b0;
        result = '0;

        unique case (state_reg)
            ats_pkg::ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    if (cmd.action == ats_pkg::ACT_LOAD)
                    begin
                        ready_next = 1'b0;
                        count_next = base_count;
                        ovf_next   = base_ovf;
                        if (base_count < ats_pkg::CNT_W'(ats_pkg::ENTRIES))
                        begin
                            prob_we    = 1'b1;
                            prob_waddr = base_count[ats_pkg::IDX_W-1:0];
                            prob_wdata = cmd.weight;
                            count_next = base_count + 1'b1;
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                        if (cmd.last_entry)
                        begin
                            idx_next       = '0;
                            small_top_next = '0;
                            large_top_next = '0;
                            state_next     = ats_pkg::ST_CLS_RD;
                        end
                    end
                    else
                    begin
                        prob_re     = 1'b1;
                        prob_raddr  = col_sel;
                        alias_re    = 1'b1;
                        alias_raddr = col_sel;
                        col_next    = col_sel;
                        accept_next = cmd.accept_random;
                        state_next  = ats_pkg::ST_DRAW;
                    end
                end
            end

            ats_pkg::ST_DRAW:
            begin
                if (slot_free)
                begin
                    push                = 1'b1;
                    result.result_kind  = ats_pkg::KIND_DRAW;
                    result.entry_count  = count_reg;
                    result.table_ready  = ready_reg;
                    result.overflowed   = ovf_reg;
                    if (ready_reg && (count_reg != '0))
                    begin
                        result.chosen_index = (cmp_lhs < cmp_rhs) ? col_reg : alias_rdata;
                    end
                    state_next = ats_pkg::ST_IDLE;
                end
            end

            ats_pkg::ST_CLS_RD:
            begin
                prob_re    = 1'b1;
                prob_raddr = idx_reg[ats_pkg::IDX_W-1:0];
                state_next = ats_pkg::ST_CLS_PUSH;
            end

            ats_pkg::ST_CLS_PUSH:
            begin
                if (prob_rdata < ats_pkg::ONE_FX)
                begin
                    sstk_we        = 1'b1;
                    sstk_waddr     = small_top_reg[ats_pkg::IDX_W-1:0];
                    sstk_wdata     = idx_reg[ats_pkg::IDX_W-1:0];
                    small_top_next = small_top_reg + 1'b1;
                end
                else
                begin
                    lstk_we        = 1'b1;
                    lstk_waddr     = large_top_reg[ats_pkg::IDX_W-1:0];
                    lstk_wdata     = idx_reg[ats_pkg::IDX_W-1:0];
                    large_top_next = large_top_reg + 1'b1;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = (idx_next == count_reg) ? ats_pkg::ST_PAIR_POP
                                                     : ats_pkg::ST_CLS_RD;
            end

            ats_pkg::ST_PAIR_POP:
            begin
                if ((small_top_reg != '0) && (large_top_reg != '0))
                begin
                    sstk_re        = 1'b1;
                    sstk_raddr     = ats_pkg::IDX_W'(small_top_reg - 1'b1);
                    lstk_re        = 1'b1;
                    lstk_raddr     = ats_pkg::IDX_W'(large_top_reg - 1'b1);
                    small_top_next = small_top_reg - 1'b1;
                    large_top_next = large_top_reg - 1'b1;
                    state_next     = ats_pkg::ST_PAIR_RDS;
                end
                else
                begin
                    state_next = ats_pkg::ST_FLUSH_RD;
                end
            end

            ats_pkg::ST_PAIR_RDS:
            begin
                alias_we    = 1'b1;
                alias_waddr = sstk_rdata;
                alias_wdata = lstk_rdata;
                prob_re     = 1'b1;
                prob_raddr  = sstk_rdata;
                l_idx_next  = lstk_rdata;
                state_next  = ats_pkg::ST_PAIR_RDL;
            end

            ats_pkg::ST_PAIR_RDL:
            begin
                ps_next    = prob_rdata;
                prob_re    = 1'b1;
                prob_raddr = l_idx_reg;
                state_next = ats_pkg::ST_PAIR_UPD;
            end

            ats_pkg::ST_PAIR_UPD:
            begin
                prob_we    = 1'b1;
                prob_waddr = l_idx_reg;
                prob_wdata = residue[ats_pkg::PROB_W-1:0];
                if (residue < ats_pkg::SUM_W'(ats_pkg::ONE_FX))
                begin
                    sstk_we        = 1'b1;
                    sstk_waddr     = small_top_reg[ats_pkg::IDX_W-1:0];
                    sstk_wdata     = l_idx_reg;
                    small_top_next = small_top_reg + 1'b1;
                end
                else
                begin
                    lstk_we        = 1'b1;
                    lstk_waddr     = large_top_reg[ats_pkg::IDX_W-1:0];
                    lstk_wdata     = l_idx_reg;
                    large_top_next = large_top_reg + 1'b1;
                end
                state_next = ats_pkg::ST_PAIR_POP;
            end

            ats_pkg::ST_FLUSH_RD:
            begin
                if (small_top_reg != '0)
                begin
                    sstk_re          = 1'b1;
                    sstk_raddr       = ats_pkg::IDX_W'(small_top_reg - 1'b1);
                    small_top_next   = small_top_reg - 1'b1;
                    flush_large_next = 1'b0;
                    state_next       = ats_pkg::ST_FLUSH_WR;
                end
                else if (large_top_reg != '0)
                begin
                    lstk_re          = 1'b1;
                    lstk_raddr       = ats_pkg::IDX_W'(large_top_reg - 1'b1);
                    large_top_next   = large_top_reg - 1'b1;
                    flush_large_next = 1'b1;
                    state_next       = ats_pkg::ST_FLUSH_WR;
                end
                else
                begin
                    ready_next = 1'b1;
                    state_next = ats_pkg::ST_DONE;
                end
            end

            ats_pkg::ST_FLUSH_WR:
            begin
                prob_we    = 1'b1;
                prob_waddr = flush_large_reg ? lstk_rdata : sstk_rdata;
                prob_wdata = ats_pkg::ONE_FX;
                state_next = ats_pkg::ST_FLUSH_RD;
            end

            ats_pkg::ST_DONE:
            begin
                if (slot_free)
                begin
                    push               = 1'b1;
                    result.result_kind = ats_pkg::KIND_BUILD;
                    result.entry_count = count_reg;
                    result.table_ready = ready_reg;
                    result.overflowed  = ovf_reg;
                    state_next         = ats_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = ats_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ats_pkg::ST_IDLE;
            count_reg       <= '0;
            ready_reg       <= 1'b0;
            ovf_reg         <= 1'b0;
            small_top_reg   <= '0;
            large_top_reg   <= '0;
            idx_reg         <= '0;
            flush_large_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            ready_reg       <= ready_next;
            ovf_reg         <= ovf_next;
            small_top_reg   <= small_top_next;
            large_top_reg   <= large_top_next;
            idx_reg         <= idx_next;
            flush_large_reg <= flush_large_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg    <= col_next;
        accept_reg <= accept_next;
        l_idx_reg  <= l_idx_next;
        ps_reg     <= ps_next;
    end

endmodule

@@ rtl/core/ats_out.sv @@
`timescale 1ns / 1ps

// Output holding register. A result waits here until the receiver takes it,
// while the sequencer is free to accept further input.
module ats_out (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ats_pkg::result_t result,
    output logic             slot_free,
    ats_out_if.source        res
);

    logic             valid_reg, valid_next;
    ats_pkg::result_t data_reg;

    assign slot_free = !valid_reg || res.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (push)
        begin
            valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg <= result;
        end
    end

    assign res.valid        = valid_reg;
    assign res.result_kind  = data_reg.result_kind;
    assign res.chosen_index = data_reg.chosen_index;
    assign res.entry_count  = data_reg.entry_count;
    assign res.table_ready  = data_reg.table_ready;
    assign res.overflowed   = data_reg.overflowed;

endmodule

@@ rtl/core/ats_checker.sv @@
`timescale 1ns / 1ps

module ats_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      res_valid,
    input logic                      res_ready,
    input logic                      res_kind,
    input logic [ats_pkg::IDX_W-1:0] res_index,
    input logic [ats_pkg::CNT_W-1:0] res_count,
    input logic                      res_table,
    input logic                      res_ovf
);

    // A stalled result stays and keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_kind) &&
        $stable(res_index) && $stable(res_count) && $stable(res_table) &&
        $stable(res_ovf))
    else $error("stalled result changed");

    // A built table always holds between one and the full number of entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_table |->
        (res_count != '0) && (res_count <= ats_pkg::CNT_W'(ats_pkg::ENTRIES)))
    else $error("table entry count out of range");

    // A build result reports a ready table and index zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_kind == ats_pkg::KIND_BUILD) |->
        res_table && (res_index == '0))
    else $error("bad build result");

    // A draw without a table returns index zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_kind == ats_pkg::KIND_DRAW) && !res_table |->
        res_index == '0)
    else $error("draw without table gave nonzero index");

    // A draw from a table picks one of its entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_kind == ats_pkg::KIND_DRAW) && res_table |->
        ats_pkg::CNT_W'(res_index) < res_count)
    else $error("drawn index outside the table");

endmodule

bind alias_table_sampler_unit ats_checker u_ats_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_kind  (res.result_kind),
    .res_index (res.chosen_index),
    .res_count (res.entry_count),
    .res_table (res.table_ready),
    .res_ovf   (res.overflowed)
);

@@ test/alias_table_sampler_unit_tb.sv @@
`timescale 1ns / 1ps

module alias_table_sampler_unit_tb;
    import ats_pkg::*;

    // A 64-entry build with the worst mix of pairs, a receiver stall and a
    // sender gap together stay far below IDLE_LIMIT, so a stretch that long
    // without any transfer means a hang.
    localparam int IDLE_LIMIT   = 4000;
    localparam int TAIL_CYCLES  = 40;
    localparam int RANDOM_ITEMS = 400;
    localparam int CALM_TAIL    = 60;
    localparam int REPORT_CAP   = 40;

    // The largest normalized weight: every entry but one is zero.
    localparam logic [PROB_W-1:0] WEIGHT_TOP = PROB_W'(ENTRIES << FRAC_BITS);

    typedef enum int {
        MIX_EVEN,
        MIX_SKEWED,
        MIX_ROUGH
    } weight_mix_t;

    // One command as the sender sees it. The drain flag makes the sender
    // wait until every expected result has come back before offering it.
    // The calm flag switches idling off on both sides while it is in flight.
    typedef struct {
        logic              action;
        logic [PROB_W-1:0] weight;
        logic              last_entry;
        logic [RND_W-1:0]  pick_random;
        logic [RND_W-1:0]  accept_random;
        bit                wait_drain;
        bit                calm;
    } sampler_cmd_t;

    logic clk;
    logic rst_n;

    ats_in_if  cmd_bus ();
    ats_out_if res_bus ();

    alias_table_sampler_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .res   (res_bus)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Commands waiting to be offered, and the results the table mirror
    // predicts for commands that have already been transferred.
    sampler_cmd_t cmd_backlog[$];
    result_t      expected_results[$];

    int unsigned predicted_total;
    int unsigned matched_total;
    int          mismatches;
    int          stimulus_count;
    bit          calm_fill;
    bit          drain_next;
    bit          calm_now;

    sampler_cmd_t on_bus;
    int           gap_left;
    int           stall_left;
    int           idle_cycles;

    // Mirror of the alias table: probabilities, aliases, fill level and flags.
    logic [PROB_W-1:0] prob_mirror [ENTRIES];
    logic [IDX_W-1:0]  alias_mirror [ENTRIES];
    int unsigned       loaded_mirror;
    bit                built_mirror;
    bit                dropped_mirror;

    task automatic report_mismatch(string what, int got, int want);
        if (mismatches < REPORT_CAP)
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Walker's construction over the loaded entries. Entries below one go on
    // the small stack, the rest on the large stack. Each pairing hands the
    // small entry's shortfall to the large one; whatever remains on either
    // stack when one runs dry is set to exactly one.
    function automatic void build_alias_mirror();
        int unsigned       small_q[$];
        int unsigned       large_q[$];
        int unsigned       s;
        int unsigned       l;
        logic [SUM_W-1:0]  residue;
        for (int i = 0; i < ENTRIES; i++)
            alias_mirror[i] = '0;
        for (int i = 0; i < loaded_mirror; i++)
        begin
            if (prob_mirror[i] < ONE_FX)
                small_q.insert(small_q.size(), i);
            else
                large_q.insert(large_q.size(), i);
        end
        while (small_q.size() != 0 && large_q.size() != 0)
        begin
            s = small_q[$];
            small_q.delete(small_q.size() - 1);
            l = large_q[$];
            large_q.delete(large_q.size() - 1);
            alias_mirror[s] = IDX_W'(l);
            residue = SUM_W'(prob_mirror[l]) + SUM_W'(prob_mirror[s]);
            // The residue never goes below zero.
            residue = (residue > SUM_W'(ONE_FX)) ? residue - SUM_W'(ONE_FX) : '0;
            prob_mirror[l] = residue[PROB_W-1:0];
            if (residue < SUM_W'(ONE_FX))
                small_q.insert(small_q.size(), l);
            else
                large_q.insert(large_q.size(), l);
        end
        foreach (small_q[i])
            prob_mirror[small_q[i]] = ONE_FX;
        foreach (large_q[i])
            prob_mirror[large_q[i]] = ONE_FX;
        built_mirror = 1'b1;
    endfunction

    // Applies one transferred command to the mirror and queues the result
    // it must produce, if any.
    function automatic void predict_cmd(sampler_cmd_t c);
        result_t     r;
        int unsigned col;
        r = '0;
        if (c.action == ACT_LOAD)
        begin
            // The first load after a finished build starts a fresh table.
            if (built_mirror)
            begin
                built_mirror   = 1'b0;
                loaded_mirror  = 0;
                dropped_mirror = 1'b0;
            end
            if (loaded_mirror < ENTRIES)
            begin
                prob_mirror[loaded_mirror] = c.weight;
                loaded_mirror++;
            end
            else
                dropped_mirror = 1'b1;
            if (!c.last_entry)
                return;
            build_alias_mirror();
            r.result_kind = KIND_BUILD;
        end
        else
        begin
            r.result_kind = KIND_DRAW;
            // Without a built table a draw returns index zero.
            if (built_mirror && loaded_mirror != 0)
            begin
                col = (32'(c.pick_random) * loaded_mirror) >> RND_W;
                if (col >= ENTRIES)
                    col = ENTRIES - 1;
                if (32'(c.accept_random) < 32'(prob_mirror[col]))
                    r.chosen_index = IDX_W'(col);
                else
                    r.chosen_index = alias_mirror[col];
            end
        end
        r.entry_count = CNT_W'(loaded_mirror);
        r.table_ready = built_mirror;
        r.overflowed  = dropped_mirror;
        expected_results.insert(expected_results.size(), r);
        predicted_total++;
    endfunction

    function automatic logic [RND_W-1:0] uniform_draw();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return RND_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // Weights with no regard for the normalization, biased toward one.
    function automatic logic [PROB_W-1:0] rough_weight();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return ONE_FX - 1'b1;
            2:       return ONE_FX;
            3:       return ONE_FX + 1'b1;
            4:       return WEIGHT_TOP;
            5:       return PROB_W'($urandom_range(0, 2 << FRAC_BITS));
            default: return PROB_W'($urandom_range(0, WEIGHT_TOP));
        endcase
    endfunction

    task automatic add_cmd(logic action, logic [PROB_W-1:0] weight, logic last_entry,
                           logic [RND_W-1:0] pick, logic [RND_W-1:0] accept);
        sampler_cmd_t c;
        c.action        = action;
        c.weight        = weight;
        c.last_entry    = last_entry;
        c.pick_random   = pick;
        c.accept_random = accept;
        c.wait_drain    = drain_next;
        c.calm          = calm_fill;
        drain_next      = 1'b0;
        cmd_backlog.insert(cmd_backlog.size(), c);
        stimulus_count++;
    endtask

    // Draws carry random load fields too, which the block must ignore.
    task automatic add_draws(int count);
        for (int i = 0; i < count; i++)
            add_cmd(ACT_DRAW, rough_weight(), 1'($urandom_range(0, 1)),
                    uniform_draw(), uniform_draw());
    endtask

    // Loads n weights. Even and skewed mixes are normalized so that they sum
    // to exactly n; the rough mix is not. With extra above zero the table is
    // filled and then overrun by that many loads, one draw falling between the
    // first two of them if extra is above one, and only the last overrunning load starts the build.
    task automatic add_table(int n, weight_mix_t mix, int extra);
        longint unsigned raw[$];
        longint unsigned total;
        longint unsigned placed;
        longint unsigned span;
        longint unsigned w;
        total  = 0;
        placed = 0;
        span   = longint'(n) << FRAC_BITS;
        for (int i = 0; i < n; i++)
        begin
            if (mix == MIX_SKEWED && $urandom_range(0, 2) == 0)
                raw.insert(raw.size(), $urandom_range(0, 3));
            else
                raw.insert(raw.size(), $urandom_range(1, 1000));
            total += raw[i];
        end
        if (total == 0)
        begin
            raw[0] = 1;
            total  = 1;
        end
        for (int i = 0; i < n; i++)
        begin
            if (mix == MIX_ROUGH)
                w = rough_weight();
            else if (i == n - 1)
                w = span - placed;
            else
                w = raw[i] * span / total;
            placed += w;
            add_cmd(ACT_LOAD, PROB_W'(w), 1'(extra == 0 && i == n - 1),
                    uniform_draw(), uniform_draw());
        end
        for (int i = 0; i < extra; i++)
        begin
            if (i == 1)
                add_draws(1);
            add_cmd(ACT_LOAD, rough_weight(), 1'(i == extra - 1), uniform_draw(), uniform_draw());
        end
    endtask

    // Sender. A command leaves the backlog only when the previous transfer
    // has happened, no idle burst is running and, for a draining command,
    // every predicted result has been matched. The prediction is made at the
    // transfer edge, so the mirror follows the order the block sees.
    always @(posedge clk)
    begin
        bit showing;
        if (rst_n)
        begin
            showing = cmd_bus.valid;
            if (cmd_bus.valid && cmd_bus.ready)
            begin
                predict_cmd(on_bus);
                showing = 1'b0;
            end
            if (!showing)
            begin
                if (gap_left != 0)
                    gap_left--;
                else if (cmd_backlog.size() != 0 &&
                         !(cmd_backlog[0].wait_drain && predicted_total != matched_total))
                begin
                    if (!cmd_backlog[0].calm && $urandom_range(0, 5) == 0)
                        gap_left = $urandom_range(0, 14);
                    else
                    begin
                        on_bus = cmd_backlog.pop_front();
                        cmd_bus.action        <= on_bus.action;
                        cmd_bus.weight        <= on_bus.weight;
                        cmd_bus.last_entry    <= on_bus.last_entry;
                        cmd_bus.pick_random   <= on_bus.pick_random;
                        cmd_bus.accept_random <= on_bus.accept_random;
                        calm_now              <= on_bus.calm;
                        showing = 1'b1;
                    end
                end
            end
            cmd_bus.valid <= showing;
        end
    end

    // Receiver. Every result transfer is compared field by field with the
    // oldest prediction; ready drops in random bursts unless the command on
    // the way is marked calm.
    always @(posedge clk)
    begin
        result_t want;
        bit      take;
        if (rst_n)
        begin
            if (res_bus.valid && res_bus.ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result_kind with nothing expected", res_bus.result_kind, -1);
                else
                begin
                    want = expected_results.pop_front();
                    if (res_bus.result_kind !== want.result_kind)
                        report_mismatch("result_kind", res_bus.result_kind, want.result_kind);
                    if (res_bus.chosen_index !== want.chosen_index)
                        report_mismatch("chosen_index", res_bus.chosen_index, want.chosen_index);
                    if (res_bus.entry_count !== want.entry_count)
                        report_mismatch("entry_count", res_bus.entry_count, want.entry_count);
                    if (res_bus.table_ready !== want.table_ready)
                        report_mismatch("table_ready", res_bus.table_ready, want.table_ready);
                    if (res_bus.overflowed !== want.overflowed)
                        report_mismatch("overflowed", res_bus.overflowed, want.overflowed);
                    matched_total <= matched_total + 1;
                end
            end
            if (stall_left != 0)
            begin
                stall_left--;
                take = 1'b0;
            end
            else if (!calm_now && $urandom_range(0, 6) == 0)
            begin
                stall_left = $urandom_range(0, 14);
                take = 1'b0;
            end
            else
                take = 1'b1;
            res_bus.ready <= take;
        end
    end

    // Watchdog: a long stretch without any transfer on either side is a hang.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int  random_end;
        bit  did_overflow;
        bit  did_full;
        int  n;

        rst_n                 = 1'b0;
        cmd_bus.valid         = 1'b0;
        cmd_bus.action        = ACT_LOAD;
        cmd_bus.weight        = '0;
        cmd_bus.last_entry    = 1'b0;
        cmd_bus.pick_random   = '0;
        cmd_bus.accept_random = '0;
        res_bus.ready         = 1'b0;
        predicted_total       = 0;
        matched_total         = 0;
        mismatches            = 0;
        stimulus_count        = 0;
        calm_fill             = 1'b0;
        drain_next            = 1'b0;
        calm_now              = 1'b0;
        gap_left              = 0;
        stall_left            = 0;
        idle_cycles           = 0;
        loaded_mirror         = 0;
        built_mirror          = 1'b0;
        dropped_mirror        = 1'b0;
        did_overflow          = 1'b0;
        did_full              = 1'b0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            prob_mirror[i]  = '0;
            alias_mirror[i] = '0;
        end

        // A draw before any table exists returns index zero, not ready.
        add_cmd(ACT_DRAW, '0, 1'b0, '0, '0);
        // A draw while the table is only partly loaded sees the fill level.
        add_cmd(ACT_LOAD, '0, 1'b0, '1, '1);
        add_cmd(ACT_DRAW, '1, 1'b1, '1, '1);
        // Weights zero and the top of the range: column 0 always takes its alias.
        add_cmd(ACT_LOAD, WEIGHT_TOP, 1'b1, '0, '0);
        add_cmd(ACT_DRAW, '0, 1'b0, '0, '0);
        add_cmd(ACT_DRAW, '0, 1'b0, '1, '1);
        add_cmd(ACT_DRAW, '0, 1'b0, RND_W'(1 << (RND_W - 1)), RND_W'(1));
        // A single entry of exactly one, offered only after the block drained.
        drain_next = 1'b1;
        add_cmd(ACT_LOAD, ONE_FX, 1'b1, '0, '0);
        add_cmd(ACT_DRAW, '0, 1'b0, '1, '1);
        // One paired with zero: the residue lands exactly on zero.
        add_cmd(ACT_LOAD, ONE_FX, 1'b0, '0, '0);
        add_cmd(ACT_LOAD, '0, 1'b1, '0, '0);
        add_cmd(ACT_DRAW, '0, 1'b0, '0, '0);
        add_cmd(ACT_DRAW, '0, 1'b0, '1, '0);
        // Just below and just above one: the accept test sits at its boundary.
        add_cmd(ACT_LOAD, ONE_FX - 1'b1, 1'b0, '0, '0);
        add_cmd(ACT_LOAD, ONE_FX + 1'b1, 1'b1, '0, '0);
        add_cmd(ACT_DRAW, '0, 1'b0, '0, RND_W'(16'hFFFE));
        add_cmd(ACT_DRAW, '0, 1'b0, '0, '1);

        // Random part: mostly normalized tables with draws on them, some
        // rough tables, loose noise, one full table and one overrun table.
        random_end = stimulus_count + RANDOM_ITEMS;
        while (stimulus_count < random_end)
        begin
            calm_fill  = (stimulus_count >= random_end - CALM_TAIL) || ($urandom_range(0, 4) == 0);
            drain_next = ($urandom_range(0, 9) == 0);
            if (!did_overflow && stimulus_count >= random_end / 3)
            begin
                add_table(ENTRIES, MIX_EVEN, $urandom_range(1, 3));
                add_draws($urandom_range(4, 8));
                did_overflow = 1'b1;
            end
            else if (!did_full && stimulus_count >= random_end / 2)
            begin
                add_table(ENTRIES, MIX_SKEWED, 0);
                add_draws($urandom_range(6, 10));
                did_full = 1'b1;
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2:
                    begin
                        add_table($urandom_range(1, 8), MIX_EVEN, 0);
                        add_draws($urandom_range(2, 8));
                    end
                    3, 4, 5:
                    begin
                        add_table($urandom_range(1, 8), MIX_SKEWED, 0);
                        add_draws($urandom_range(2, 8));
                    end
                    6, 7:
                    begin
                        add_table($urandom_range(1, 8), MIX_ROUGH, 0);
                        add_draws($urandom_range(2, 6));
                    end
                    8:
                    begin
                        n = $urandom_range(1, 4);
                        repeat (n)
                            add_cmd(1'($urandom_range(0, 1)), rough_weight(),
                                    1'($urandom_range(0, 3) == 0), uniform_draw(), uniform_draw());
                    end
                    default:
                    begin
                        add_table($urandom_range(9, 24), MIX_SKEWED, 0);
                        add_draws($urandom_range(3, 8));
                    end
                endcase
            end
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for the last command transfer, then for the last result.
        while (cmd_backlog.size() != 0 || cmd_bus.valid)
            @(posedge clk);
        while (matched_total != predicted_total)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (expected_results.size() != 0)
            report_mismatch("results still expected", 0, expected_results.size());
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
